// ===== src/pwtp_pkg.sv =====
// Shared types and constants for the protobuf wire token parser.
// Used by the parser core, the token queue and the top level; no dependencies.
package pwtp_pkg;

  localparam int unsigned MAX_MESSAGE_BYTES = 65536;
  localparam int unsigned PAY_W = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam logic [63:0] MAX_LEN = 64'(MAX_MESSAGE_BYTES);

  localparam logic [6:0] VARINT_MASK = 7'h7f;
  localparam int unsigned VARINT_MAX_BYTES = 10;
  localparam int unsigned VALUE_BITS = 64;

  typedef enum logic [2:0] {
    KIND_SCALAR  = 3'd0,
    KIND_HEADER  = 3'd1,
    KIND_PAYLOAD = 3'd2,
    KIND_END     = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_TAG  = 2'd1,
    ERR_TRUNC    = 2'd2,
    ERR_WIRETYPE = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    WT_VARINT  = 3'd0,
    WT_FIXED64 = 3'd1,
    WT_LENGTH  = 3'd2,
    WT_FIXED32 = 3'd5
  } wire_e;

  typedef enum logic [5:0] {
    PH_TAG     = 6'b000001,
    PH_VARINT  = 6'b000010,
    PH_FIXED   = 6'b000100,
    PH_LENGTH  = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_DROP    = 6'b100000
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] field_number;
    logic [2:0]  wire_type;
    logic [63:0] value;
    logic [7:0]  payload_byte;
    err_e        error_code;
    logic        last_of_run;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } push_t;

endpackage

// ===== src/pwtp_parser.sv =====
// Parser core: phase register, accumulator and field state, and the decode
// of one byte into up to two tokens. Depends on pwtp_pkg.
module pwtp_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  logic [7:0]     data_byte_i,
  input  logic           final_byte_i,
  output pwtp_pkg::push_t push_o
);
  import pwtp_pkg::*;

  phase_e            phase_q, phase_d;
  logic [63:0]       acc_q, acc_d;
  logic [3:0]        pos_q, pos_d;
  logic [31:0]       fn_q, fn_d;
  logic [2:0]        wt_q, wt_d;
  logic [PAY_W-1:0]  rem_q, rem_d;

  logic [6:0]        sh7;
  logic [63:0]       acc_v;
  logic [63:0]       acc_f;
  logic [3:0]        pos_n;
  logic [3:0]        need;
  logic [PAY_W-1:0]  rem_n;
  logic              cont;
  logic              err_set;
  err_e              err_code;
  logic              done_set;
  logic              slot;
  logic              overlong;
  token_t            t0, t1, ev;
  logic [1:0]        cnt;

  always_comb begin
    sh7   = {3'b000, pos_q} * 7'd7;
    acc_v = acc_q;
    if (sh7 < 7'(VALUE_BITS)) begin
      acc_v = acc_q | ({57'b0, data_byte_i[6:0] & VARINT_MASK} << sh7[5:0]);
    end
    acc_f    = acc_q | ({56'b0, data_byte_i} << {pos_q[2:0], 3'b000});
    pos_n    = pos_q + 4'd1;
    cont     = data_byte_i[7];
    overlong = cont && (pos_n >= 4'(VARINT_MAX_BYTES));
    need     = (wt_q == WT_FIXED64) ? 4'd8 : 4'd4;
    rem_n    = (rem_q != '0) ? rem_q - PAY_W'(1) : rem_q;
  end

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    pos_d    = pos_q;
    fn_d     = fn_q;
    wt_d     = wt_q;
    rem_d    = rem_q;
    t0       = '0;
    t1       = '0;
    ev       = '0;
    cnt      = 2'd0;
    err_set  = 1'b0;
    err_code = ERR_NONE;
    done_set = 1'b0;
    slot     = 1'b0;

    unique case (phase_q) inside
      PH_TAG: begin
        if (overlong) begin
          err_set  = 1'b1;
          err_code = ERR_BAD_TAG;
        end else if (cont) begin
          acc_d = acc_v;
          pos_d = pos_n;
          if (final_byte_i) begin
            err_set  = 1'b1;
            err_code = ERR_TRUNC;
          end
        end else if (acc_v == '0) begin
          err_set  = 1'b1;
          err_code = ERR_BAD_TAG;
        end else begin
          fn_d  = acc_v[34:3];
          wt_d  = acc_v[2:0];
          acc_d = '0;
          pos_d = '0;
          case (acc_v[2:0]) inside
            WT_VARINT:              phase_d = PH_VARINT;
            WT_FIXED64, WT_FIXED32: phase_d = PH_FIXED;
            WT_LENGTH:              phase_d = PH_LENGTH;
            default: begin
              err_set  = 1'b1;
              err_code = ERR_WIRETYPE;
            end
          endcase
          if (!err_set && final_byte_i) begin
            err_set  = 1'b1;
            err_code = ERR_TRUNC;
          end
        end
      end
      PH_VARINT, PH_LENGTH: begin
        if (overlong) begin
          err_set  = 1'b1;
          err_code = ERR_BAD_TAG;
        end else if (cont) begin
          acc_d = acc_v;
          pos_d = pos_n;
          if (final_byte_i) begin
            err_set  = 1'b1;
            err_code = ERR_TRUNC;
          end
        end else if (phase_q == PH_VARINT) begin
          t0.kind         = KIND_SCALAR;
          t0.field_number = fn_q;
          t0.wire_type    = wt_q;
          t0.value        = acc_v;
          cnt             = 2'd1;
          done_set        = 1'b1;
          slot            = 1'b1;
        end else if (acc_v > MAX_LEN) begin
          err_set  = 1'b1;
          err_code = ERR_TRUNC;
        end else begin
          t0.kind         = KIND_HEADER;
          t0.field_number = fn_q;
          t0.wire_type    = wt_q;
          t0.value        = acc_v;
          cnt             = 2'd1;
          slot            = 1'b1;
          if (acc_v == '0) begin
            done_set = 1'b1;
          end else begin
            rem_d   = acc_v[PAY_W-1:0];
            acc_d   = '0;
            pos_d   = '0;
            phase_d = PH_PAYLOAD;
            if (final_byte_i) begin
              err_set  = 1'b1;
              err_code = ERR_TRUNC;
            end
          end
        end
      end
      PH_FIXED: begin
        if (pos_n < need) begin
          acc_d = acc_f;
          pos_d = pos_n;
          if (final_byte_i) begin
            err_set  = 1'b1;
            err_code = ERR_TRUNC;
          end
        end else begin
          t0.kind         = KIND_SCALAR;
          t0.field_number = fn_q;
          t0.wire_type    = wt_q;
          t0.value        = acc_f;
          cnt             = 2'd1;
          done_set        = 1'b1;
          slot            = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        t0.kind         = KIND_PAYLOAD;
        t0.field_number = fn_q;
        t0.wire_type    = wt_q;
        t0.payload_byte = data_byte_i;
        cnt             = 2'd1;
        slot            = 1'b1;
        rem_d           = rem_n;
        if (rem_n == '0) begin
          done_set = 1'b1;
        end else if (final_byte_i) begin
          err_set  = 1'b1;
          err_code = ERR_TRUNC;
        end
      end
      PH_DROP: begin
        if (final_byte_i) begin
          phase_d = PH_TAG;
        end
      end
      default: begin
        phase_d = PH_TAG;
        acc_d   = '0;
        pos_d   = '0;
        fn_d    = '0;
        wt_d    = '0;
        rem_d   = '0;
      end
    endcase

    if (done_set) begin
      phase_d = PH_TAG;
      acc_d   = '0;
      pos_d   = '0;
      if (final_byte_i) begin
        ev.kind = KIND_END;
        fn_d    = '0;
        wt_d    = '0;
        rem_d   = '0;
      end
    end

    if (err_set) begin
      ev.kind       = KIND_ERROR;
      ev.error_code = err_code;
      phase_d       = final_byte_i ? PH_TAG : PH_DROP;
      acc_d         = '0;
      pos_d         = '0;
      fn_d          = '0;
      wt_d          = '0;
      rem_d         = '0;
    end

    if (err_set || (done_set && final_byte_i)) begin
      if (slot) begin
        t1  = ev;
        cnt = 2'd2;
      end else begin
        t0  = ev;
        cnt = 2'd1;
      end
    end

    if (cnt == 2'd2) begin
      t1.last_of_run = 1'b1;
    end else if (cnt == 2'd1) begin
      t0.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      acc_q   <= '0;
      pos_q   <= '0;
      fn_q    <= '0;
      wt_q    <= '0;
      rem_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      pos_q   <= pos_d;
      fn_q    <= fn_d;
      wt_q    <= wt_d;
      rem_q   <= rem_d;
    end
  end

  always_comb begin
    push_o.count = fire_i ? cnt : 2'd0;
    push_o.tok0  = t0;
    push_o.tok1  = t1;
  end

endmodule

// ===== src/pwtp_token_fifo.sv =====
// Four-entry token queue that takes up to two tokens per cycle and hands
// out one while out_stall_i is low. Depends on pwtp_pkg.
module pwtp_token_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pwtp_pkg::push_t push_i,
  output logic            room2_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output pwtp_pkg::token_t tok_o
);
  import pwtp_pkg::*;

  token_t     mem_q [4];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign pop         = (cnt_q != 3'd0) && !out_stall_i;
  assign out_valid_o = (cnt_q != 3'd0);
  assign room2_o     = (cnt_q <= 3'd2);
  assign tok_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q + push_i.count;
    rd_d  = rd_q + {1'b0, pop};
    cnt_d = cnt_q + {1'b0, push_i.count} - {2'b00, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.tok0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_q + 2'd1] <= push_i.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== src/protobuf_wire_token_parser.sv =====
// Protobuf wire-format token parser: one message byte per clock in while in_stall_o is low, tokens out.
// A byte accepted is held in the input register, then parsed and queued when the token
// queue has room for two; its first token is then offered on out_valid_o.
// Throughput: one byte per cycle; a byte that yields two tokens hands them out one by one,
// and the input stalls while the four-entry queue holds three or more.
// Reset clears the parse state and the queue at once; no clearing pass.
module protobuf_wire_token_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [31:0] field_number_o,
  output logic [2:0]  wire_type_o,
  output logic [63:0] value_o,
  output logic [7:0]  payload_byte_o,
  output logic [1:0]  error_code_o,
  output logic        last_of_run_o
);
  import pwtp_pkg::*;

  logic       in_vld_q;
  logic [7:0] data_q;
  logic       final_q;
  logic       room2;
  logic       fire;
  push_t      push;
  token_t     tok;

  assign fire       = in_vld_q && room2;
  assign in_stall_o = in_vld_q && !fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      data_q  <= data_byte_i;
      final_q <= final_byte_i;
    end
  end

  pwtp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .data_byte_i  (data_q),
    .final_byte_i (final_q),
    .push_o       (push)
  );

  pwtp_token_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tok_o       (tok)
  );

  assign kind_o         = tok.kind;
  assign field_number_o = tok.field_number;
  assign wire_type_o    = tok.wire_type;
  assign value_o        = tok.value;
  assign payload_byte_o = tok.payload_byte;
  assign error_code_o   = tok.error_code;
  assign last_of_run_o  = tok.last_of_run;

endmodule

// ===== tb/pwtp_checker.sv =====
// Checker for the protobuf wire token parser: predicts the tokens of every accepted byte
// and compares each accepted token with the oldest prediction. Depends on pwtp_pkg.
`timescale 1ns / 1ps

module pwtp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  kind_i,
  input  logic [31:0] field_number_i,
  input  logic [2:0]  wire_type_i,
  input  logic [63:0] value_i,
  input  logic [7:0]  payload_byte_i,
  input  logic [1:0]  error_code_i,
  input  logic        last_of_run_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          tokens_o,
  output int          ends_o,
  output int          errors_o
);
  import pwtp_pkg::*;

  typedef enum {TAKE_MORE, TAKE_DONE, TAKE_OVERLONG} take_e;

  phase_e      phase;
  logic [63:0] acc;
  int unsigned pos;
  logic [31:0] held_fn;
  logic [2:0]  held_wt;
  logic [31:0] pay_left;
  bit          drop_hold;

  token_t run_tok[2];
  int     run_n;
  token_t expected_tokens[$];

  int fail_count;
  int tokens_seen;
  int ends_seen;
  int errors_seen;

  function void clear_parse();
    phase     = PH_TAG;
    acc       = '0;
    pos       = 0;
    held_fn   = '0;
    held_wt   = '0;
    pay_left  = '0;
    drop_hold = 1'b0;
  endfunction

  function void emit(kind_e k, logic [31:0] fn, logic [2:0] wt, logic [63:0] v,
                     logic [7:0] pb, err_e ec);
    run_tok[run_n] = '{kind: k, field_number: fn, wire_type: wt, value: v,
                       payload_byte: pb, error_code: ec, last_of_run: 1'b0};
    run_n++;
  endfunction

  function take_e take_varint(logic [7:0] b);
    if (pos * 7 < VALUE_BITS) begin
      acc |= 64'(b[6:0]) << (pos * 7);
    end
    pos++;
    if (!b[7]) begin
      return TAKE_DONE;
    end
    if (pos >= VARINT_MAX_BYTES) begin
      return TAKE_OVERLONG;
    end
    return TAKE_MORE;
  endfunction

  function void flag_error(err_e ec, bit fin);
    emit(KIND_ERROR, '0, '0, '0, '0, ec);
    clear_parse();
    if (!fin) begin
      phase     = PH_DROP;
      drop_hold = 1'b1;
    end
  endfunction

  function void finish_field(bit fin);
    phase = PH_TAG;
    acc   = '0;
    pos   = 0;
    if (fin) begin
      emit(KIND_END, '0, '0, '0, '0, ERR_NONE);
      clear_parse();
    end
  endfunction

  function void predict_byte(logic [7:0] b, bit fin);
    take_e       tr;
    int unsigned need;
    bit          bad_wt;
    run_n  = 0;
    bad_wt = 1'b0;
    if (drop_hold || phase == PH_DROP) begin
      if (fin) begin
        clear_parse();
      end
    end else begin
      case (phase)
        PH_TAG: begin
          tr = take_varint(b);
          if (tr == TAKE_OVERLONG) begin
            flag_error(ERR_BAD_TAG, fin);
          end else if (tr == TAKE_MORE) begin
            if (fin) flag_error(ERR_TRUNC, 1'b1);
          end else if (acc == 0) begin
            flag_error(ERR_BAD_TAG, fin);
          end else begin
            held_fn = acc[34:3];
            held_wt = acc[2:0];
            acc     = '0;
            pos     = 0;
            case (held_wt)
              WT_VARINT:             phase = PH_VARINT;
              WT_FIXED64, WT_FIXED32: phase = PH_FIXED;
              WT_LENGTH:             phase = PH_LENGTH;
              default:               bad_wt = 1'b1;
            endcase
            if (bad_wt) begin
              flag_error(ERR_WIRETYPE, fin);
            end else if (fin) begin
              flag_error(ERR_TRUNC, 1'b1);
            end
          end
        end
        PH_VARINT: begin
          tr = take_varint(b);
          if (tr == TAKE_OVERLONG) begin
            flag_error(ERR_BAD_TAG, fin);
          end else if (tr == TAKE_MORE) begin
            if (fin) flag_error(ERR_TRUNC, 1'b1);
          end else begin
            emit(KIND_SCALAR, held_fn, held_wt, acc, '0, ERR_NONE);
            finish_field(fin);
          end
        end
        PH_FIXED: begin
          need = (held_wt == WT_FIXED64) ? 8 : 4;
          acc |= 64'(b) << ((pos % 8) * 8);
          pos++;
          if (pos < need) begin
            if (fin) flag_error(ERR_TRUNC, 1'b1);
          end else begin
            emit(KIND_SCALAR, held_fn, held_wt, acc, '0, ERR_NONE);
            finish_field(fin);
          end
        end
        PH_LENGTH: begin
          tr = take_varint(b);
          if (tr == TAKE_OVERLONG) begin
            flag_error(ERR_BAD_TAG, fin);
          end else if (tr == TAKE_MORE) begin
            if (fin) flag_error(ERR_TRUNC, 1'b1);
          end else if (acc > MAX_LEN) begin
            flag_error(ERR_TRUNC, fin);
          end else begin
            emit(KIND_HEADER, held_fn, held_wt, acc, '0, ERR_NONE);
            if (acc == 0) begin
              finish_field(fin);
            end else begin
              pay_left = acc[31:0];
              acc      = '0;
              pos      = 0;
              phase    = PH_PAYLOAD;
              if (fin) flag_error(ERR_TRUNC, 1'b1);
            end
          end
        end
        PH_PAYLOAD: begin
          emit(KIND_PAYLOAD, held_fn, held_wt, '0, b, ERR_NONE);
          if (pay_left > 0) pay_left--;
          if (pay_left == 0) begin
            finish_field(fin);
          end else if (fin) begin
            flag_error(ERR_TRUNC, 1'b1);
          end
        end
        default: clear_parse();
      endcase
    end
    if (run_n > 0) begin
      run_tok[run_n - 1].last_of_run = 1'b1;
    end
    for (int i = 0; i < run_n; i++) begin
      expected_tokens.push_back(run_tok[i]);
    end
  endfunction

  function void check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp, act);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count  = 0;
    tokens_seen = 0;
    ends_seen   = 0;
    errors_seen = 0;
    clear_parse();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    token_t exp;
    if (!rst_ni) begin
      clear_parse();
      expected_tokens.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        tokens_seen++;
        if (kind_i == KIND_END) ends_seen++;
        if (kind_i == KIND_ERROR) errors_seen++;
        if (expected_tokens.size() == 0) begin
          $error("Unexpected token: kind %0d, value %0h", kind_i, value_i);
          fail_count++;
        end else begin
          exp = expected_tokens.pop_front();
          check_field("kind", 64'(exp.kind), 64'(kind_i));
          check_field("field_number", 64'(exp.field_number), 64'(field_number_i));
          check_field("wire_type", 64'(exp.wire_type), 64'(wire_type_i));
          check_field("value", exp.value, value_i);
          check_field("payload_byte", 64'(exp.payload_byte), 64'(payload_byte_i));
          check_field("error_code", 64'(exp.error_code), 64'(error_code_i));
          check_field("last_of_run", 64'(exp.last_of_run), 64'(last_of_run_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_byte(data_byte_i, final_byte_i);
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_tokens.size();
    tokens_o     <= tokens_seen;
    ends_o       <= ends_seen;
    errors_o     <= errors_seen;
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the protobuf wire token parser testbench: clock, reset, byte stimulus and
// output stall patterns, and the verdict. Depends on pwtp_pkg, the parser and pwtp_checker.
`timescale 1ns / 1ps

module testbench;
  import pwtp_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int PHASE_BYTES  = 240;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [2:0] WT_GROUP_START = 3'd3;
  localparam logic [2:0] WT_GROUP_END   = 3'd4;
  localparam logic [2:0] WT_RESERVED6   = 3'd6;
  localparam logic [2:0] WT_RESERVED7   = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        final_byte = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  kind;
  logic [31:0] field_number;
  logic [2:0]  wire_type;
  logic [63:0] value;
  logic [7:0]  payload_byte;
  logic [1:0]  error_code;
  logic        last_of_run;

  int fail_count;
  int pending;
  int tokens;
  int ends;
  int errors;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_request = 1'b0;
  int  bytes_sent = 0;
  int  cycles = 0;

  logic [7:0] msg_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  protobuf_wire_token_parser u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .final_byte_i   (final_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (kind),
    .field_number_o (field_number),
    .wire_type_o    (wire_type),
    .value_o        (value),
    .payload_byte_o (payload_byte),
    .error_code_o   (error_code),
    .last_of_run_o  (last_of_run)
  );

  pwtp_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .data_byte_i    (data_byte),
    .final_byte_i   (final_byte),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .kind_i         (kind),
    .field_number_i (field_number),
    .wire_type_i    (wire_type),
    .value_i        (value),
    .payload_byte_i (payload_byte),
    .error_code_i   (error_code),
    .last_of_run_i  (last_of_run),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .tokens_o       (tokens),
    .ends_o         (ends),
    .errors_o       (errors)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("protobuf_wire_token_parser verification failed");
      $finish;
    end
  end

  initial begin
    bit hold_seen;
    hold_seen = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_request && !hold_seen) begin
        hold_seen = 1'b1;
        for (int i = 0; i < HOLD_CYCLES; i++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_byte(logic [7:0] b, bit fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    final_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_q.size(); i++) begin
      send_byte(msg_q[i], i == msg_q.size() - 1);
    end
    msg_q.delete();
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom} >> $urandom_range(63);
  endfunction

  function automatic int unsigned pick_pad();
    return ($urandom_range(15) == 0) ? $urandom_range(1, 4) : 0;
  endfunction

  function automatic void push_varint(logic [63:0] v, int unsigned pad);
    int unsigned n;
    int unsigned total;
    logic [63:0] t;
    n = 1;
    t = v >> 7;
    while (t != 0) begin
      n++;
      t = t >> 7;
    end
    total = (n + pad > 10) ? 10 : n + pad;
    t = v;
    for (int unsigned i = 0; i < total; i++) begin
      msg_q.push_back({(i + 1 < total), t[6:0]});
      t = t >> 7;
    end
  endfunction

  function automatic void push_tag(logic [2:0] wt);
    logic [63:0] fn;
    int unsigned r;
    r = $urandom_range(9);
    if (r < 5) begin
      fn = 64'($urandom_range(1, 15));
    end else if (r < 8) begin
      fn = 64'($urandom);
    end else begin
      fn = rand64() >> 3;
    end
    push_varint((fn << 3) | 64'(wt), pick_pad());
  endfunction

  function automatic void push_field();
    int unsigned r;
    int unsigned len;
    logic [2:0]  bad_wt;
    r = $urandom_range(99);
    if (r < 28) begin
      push_tag(WT_VARINT);
      push_varint(rand64(), pick_pad());
    end else if (r < 42) begin
      push_tag(WT_FIXED64);
      repeat (8) msg_q.push_back(8'($urandom));
    end else if (r < 56) begin
      push_tag(WT_FIXED32);
      repeat (4) msg_q.push_back(8'($urandom));
    end else if (r < 84) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 5);
      push_tag(WT_LENGTH);
      push_varint(64'(len), pick_pad());
      repeat (len) msg_q.push_back(8'($urandom));
    end else if (r < 87) begin
      push_varint(64'd0, pick_pad());
    end else if (r < 91) begin
      case ($urandom_range(3))
        0:       bad_wt = WT_GROUP_START;
        1:       bad_wt = WT_GROUP_END;
        2:       bad_wt = WT_RESERVED6;
        default: bad_wt = WT_RESERVED7;
      endcase
      push_tag(bad_wt);
      repeat ($urandom_range(0, 3)) msg_q.push_back(8'($urandom));
    end else if (r < 94) begin
      if ($urandom_range(1)) push_tag($urandom_range(1) ? WT_VARINT : WT_LENGTH);
      repeat (10) msg_q.push_back(8'h80 | 8'($urandom_range(127)));
      repeat ($urandom_range(0, 2)) msg_q.push_back(8'($urandom));
    end else if (r < 97) begin
      push_tag(WT_LENGTH);
      push_varint(MAX_LEN + 1 + 64'($urandom_range(0, 1000)) *
                  64'($urandom_range(0, 1)) + (rand64() & {64{$urandom_range(7) == 0}}),
                  pick_pad());
    end else begin
      push_tag(WT_LENGTH);
      push_varint(MAX_LEN, 0);
      repeat ($urandom_range(0, 4)) msg_q.push_back(8'($urandom));
    end
  endfunction

  function automatic void build_message();
    int unsigned r;
    int unsigned keep;
    r = $urandom_range(99);
    msg_q.delete();
    if (r < 6) begin
      repeat ($urandom_range(1, 6)) msg_q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) push_field();
      if (r < 20) begin
        keep = $urandom_range(1, msg_q.size());
        while (msg_q.size() > keep) void'(msg_q.pop_back());
      end
    end
  endfunction

  task automatic run_phase(int idle_pct, int stall_pct, int n_bytes);
    int start;
    start          = bytes_sent;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (bytes_sent - start < n_bytes) begin
      build_message();
      send_message();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero tag on a one-byte message.
    msg_q = '{8'h00};
    send_message();
    // Varint zero, fixed32, and an empty length field, then a clean end.
    msg_q = '{8'h08, 8'h00, 8'h0D, 8'hAA, 8'hBB, 8'hCC, 8'hDD, 8'h12, 8'h00};
    send_message();
    // Unsupported wire type, with the trailing bytes dropped.
    msg_q = '{8'h0B, 8'h55, 8'hFF};
    send_message();
    // Payload cut short by the final byte.
    msg_q = '{8'h12, 8'h02, 8'hFF};
    send_message();
    // Length one above the limit.
    msg_q = '{8'h12, 8'h81, 8'h80, 8'h04};
    send_message();

    run_phase(0, 0, PHASE_BYTES);
    run_phase(81, 0, PHASE_BYTES);
    run_phase(0, 81, PHASE_BYTES);
    run_phase(15, 15, PHASE_BYTES);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    run_phase(0, 0, 80);

    in_valid <= 1'b0;
    recv_stall_pct = 15;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d message bytes under four idle mixes and one long output hold-off.",
             bytes_sent);
    $display("Checked %0d tokens, %0d of them message ends and %0d errors.",
             tokens, ends, errors);
    if (fail_count == 0 && pending == 0) begin
      $display("protobuf_wire_token_parser verification clean");
    end else begin
      $display("%0d mismatches, %0d tokens never arrived.", fail_count, pending);
      $display("protobuf_wire_token_parser verification failed");
    end
    $finish;
  end

endmodule
